FILE: hw/rtl/trsp_pkg.sv
// Shared types and codes for the tagged record stream parser.
// No dependencies; imported by tagged_record_stream_parser.
package trsp_pkg;

   // Configuration register indexes (byte address = 4 * index)
   localparam int unsigned CsrAddrWidth = 5;
   localparam logic [2:0] REG_TARGET_TAG  = 3'd0;
   localparam logic [2:0] REG_CODE_U8     = 3'd1;
   localparam logic [2:0] REG_CODE_U16    = 3'd2;
   localparam logic [2:0] REG_CODE_U32    = 3'd3;
   localparam logic [2:0] REG_CODE_STRING = 3'd4;
   localparam logic [2:0] REG_CODE_BYTES  = 3'd5;

   localparam logic [7:0] RESET_CODE_U8     = 8'd1;
   localparam logic [7:0] RESET_CODE_U16    = 8'd2;
   localparam logic [7:0] RESET_CODE_U32    = 8'd3;
   localparam logic [7:0] RESET_CODE_STRING = 8'd4;
   localparam logic [7:0] RESET_CODE_BYTES  = 8'd5;

   // Record kinds
   localparam logic [2:0] KIND_U8     = 3'd0;
   localparam logic [2:0] KIND_U16    = 3'd1;
   localparam logic [2:0] KIND_U32    = 3'd2;
   localparam logic [2:0] KIND_STRING = 3'd3;
   localparam logic [2:0] KIND_BYTES  = 3'd4;

   // Result status codes
   localparam logic [2:0] ST_VALUE   = 3'd0;
   localparam logic [2:0] ST_PAYLOAD = 3'd1;
   localparam logic [2:0] ST_TRUNC   = 3'd2;
   localparam logic [2:0] ST_UNKNOWN = 3'd3;
   localparam logic [2:0] ST_TERM    = 3'd4;
   localparam logic [2:0] ST_CLEAN   = 3'd5;

   typedef struct packed {
      logic        valid;
      logic [7:0]  rec_tag;
      logic [2:0]  rec_kind;
      logic [31:0] rec_value;
      logic        payload_last;
      logic [2:0]  status;
      logic        buffer_done;
   } result_type;

endpackage

FILE: hw/rtl/tagged_record_stream_parser.sv
// Tagged record stream parser: byte-serial tag/type/value decoder.
// Depends on trsp_pkg (codes, result struct).
//
// Takes one buffer byte per item on the req_ channel and returns zero or one
// result per byte on the rsp_ channel. An item is accepted every clock while
// the result register is empty or being drained in the same cycle; the result
// for a byte appears in the cycle after it is accepted. The per-byte phase
// update and result selection is a single level of logic between the parser
// state and the result register. The user sets type codes and the target tag
// via csr_ while the block is idle, unenforced; no clearing pass after reset.
module tagged_record_stream_parser
   import trsp_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // input item channel
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              req_in_byte,
   input  logic                    req_in_last,
   // result channel
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [7:0]              rsp_rec_tag,
   output logic [2:0]              rsp_rec_kind,
   output logic [31:0]             rsp_rec_value,
   output logic                    rsp_payload_last,
   output logic [2:0]              rsp_status,
   output logic                    rsp_buffer_done,
   // configuration port
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [31:0]             csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);

   typedef enum logic [2:0] {
      PH_TAG,
      PH_TYPE,
      PH_VALUE,
      PH_LEN,
      PH_PAYLOAD
   } phase_type;

   // configuration registers
   logic [7:0] target_tag_ff, code_u8_ff, code_u16_ff, code_u32_ff;
   logic [7:0] code_string_ff, code_bytes_ff;
   logic [2:0] csr_index;
   logic       csr_write;

   // parser state
   phase_type   phase_ff, phase_in;
   logic [7:0]  cur_tag_ff, cur_tag_in;
   logic [2:0]  cur_kind_ff, cur_kind_in;
   logic [15:0] remaining_ff, remaining_in;
   logic [31:0] accum_ff, accum_in;
   logic        match_ff, match_in;
   logic        halted_ff, halted_in;

   // result register
   result_type  rsp_ff, res_in;

   logic        accept;
   logic        rsp_load;
   logic [15:0] rem_dec;
   logic [31:0] acc_shift;
   logic [15:0] len_value;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[CsrAddrWidth-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_tag_ff  <= 8'd0;
         code_u8_ff     <= RESET_CODE_U8;
         code_u16_ff    <= RESET_CODE_U16;
         code_u32_ff    <= RESET_CODE_U32;
         code_string_ff <= RESET_CODE_STRING;
         code_bytes_ff  <= RESET_CODE_BYTES;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_TARGET_TAG:  target_tag_ff  <= csr_pwdata[7:0];
            REG_CODE_U8:     code_u8_ff     <= csr_pwdata[7:0];
            REG_CODE_U16:    code_u16_ff    <= csr_pwdata[7:0];
            REG_CODE_U32:    code_u32_ff    <= csr_pwdata[7:0];
            REG_CODE_STRING: code_string_ff <= csr_pwdata[7:0];
            REG_CODE_BYTES:  code_bytes_ff  <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_TARGET_TAG:  csr_prdata = {24'd0, target_tag_ff};
         REG_CODE_U8:     csr_prdata = {24'd0, code_u8_ff};
         REG_CODE_U16:    csr_prdata = {24'd0, code_u16_ff};
         REG_CODE_U32:    csr_prdata = {24'd0, code_u32_ff};
         REG_CODE_STRING: csr_prdata = {24'd0, code_string_ff};
         REG_CODE_BYTES:  csr_prdata = {24'd0, code_bytes_ff};
         default:         csr_prdata = 32'd0;
      endcase
   end

   assign req_ready = !rsp_ff.valid || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rem_dec   = remaining_ff - 16'd1;
   assign acc_shift = {accum_ff[23:0], req_in_byte};
   assign len_value = acc_shift[15:0];

   // next state and result for the byte at the input
   always_comb begin
      phase_in     = phase_ff;
      cur_tag_in   = cur_tag_ff;
      cur_kind_in  = cur_kind_ff;
      remaining_in = remaining_ff;
      accum_in     = accum_ff;
      match_in     = match_ff;
      halted_in    = halted_ff;
      res_in       = '{valid: 1'b0, rec_tag: 8'd0, rec_kind: KIND_U8, rec_value: 32'd0,
                       payload_last: 1'b0, status: ST_VALUE, buffer_done: req_in_last};

      if (halted_ff) begin
         if (req_in_last) begin
            halted_in = 1'b0;
            phase_in  = PH_TAG;
         end
      end else begin
         unique case (phase_ff)
            PH_TYPE: begin
               accum_in = 32'd0;
               priority if (req_in_byte == code_u8_ff) begin
                  cur_kind_in = KIND_U8;  remaining_in = 16'd1; phase_in = PH_VALUE;
               end else if (req_in_byte == code_u16_ff) begin
                  cur_kind_in = KIND_U16; remaining_in = 16'd2; phase_in = PH_VALUE;
               end else if (req_in_byte == code_u32_ff) begin
                  cur_kind_in = KIND_U32; remaining_in = 16'd4; phase_in = PH_VALUE;
               end else if (req_in_byte == code_string_ff) begin
                  cur_kind_in = KIND_STRING; remaining_in = 16'd1; phase_in = PH_LEN;
               end else if (req_in_byte == code_bytes_ff) begin
                  cur_kind_in = KIND_BYTES;  remaining_in = 16'd2; phase_in = PH_LEN;
               end else begin
                  accum_in         = accum_ff;
                  phase_in         = PH_TAG;
                  halted_in        = !req_in_last;
                  res_in.valid     = 1'b1;
                  res_in.rec_tag   = cur_tag_ff;
                  res_in.rec_value = {24'd0, req_in_byte};
                  res_in.status    = ST_UNKNOWN;
               end
               // type known but buffer ends here
               if (phase_in != PH_TAG && req_in_last) begin
                  phase_in        = PH_TAG;
                  res_in.valid    = 1'b1;
                  res_in.rec_tag  = cur_tag_ff;
                  res_in.rec_kind = cur_kind_in;
                  res_in.status   = ST_TRUNC;
               end
            end
            PH_VALUE: begin
               accum_in     = acc_shift;
               remaining_in = rem_dec;
               if (rem_dec == 16'd0) begin
                  phase_in = PH_TAG;
                  if (match_ff) begin
                     res_in.valid     = 1'b1;
                     res_in.rec_tag   = cur_tag_ff;
                     res_in.rec_kind  = cur_kind_ff;
                     res_in.rec_value = acc_shift;
                  end else if (req_in_last) begin
                     res_in.valid  = 1'b1;
                     res_in.status = ST_CLEAN;
                  end
               end else if (req_in_last) begin
                  phase_in        = PH_TAG;
                  res_in.valid    = 1'b1;
                  res_in.rec_tag  = cur_tag_ff;
                  res_in.rec_kind = cur_kind_ff;
                  res_in.status   = ST_TRUNC;
               end
            end
            PH_LEN: begin
               accum_in     = {16'd0, len_value};
               remaining_in = rem_dec;
               if (rem_dec == 16'd0 && !(len_value != 16'd0 && req_in_last)) begin
                  if (len_value == 16'd0) begin
                     phase_in = PH_TAG;
                  end else begin
                     phase_in     = PH_PAYLOAD;
                     remaining_in = len_value;
                  end
                  if (match_ff) begin
                     res_in.valid     = 1'b1;
                     res_in.rec_tag   = cur_tag_ff;
                     res_in.rec_kind  = cur_kind_ff;
                     res_in.rec_value = {16'd0, len_value};
                  end else if (req_in_last) begin
                     res_in.valid  = 1'b1;
                     res_in.status = ST_CLEAN;
                  end
               end else if (req_in_last) begin
                  phase_in        = PH_TAG;
                  res_in.valid    = 1'b1;
                  res_in.rec_tag  = cur_tag_ff;
                  res_in.rec_kind = cur_kind_ff;
                  res_in.status   = ST_TRUNC;
               end
            end
            PH_PAYLOAD: begin
               remaining_in = rem_dec;
               if (rem_dec != 16'd0 && req_in_last) begin
                  phase_in        = PH_TAG;
                  res_in.valid    = 1'b1;
                  res_in.rec_tag  = cur_tag_ff;
                  res_in.rec_kind = cur_kind_ff;
                  res_in.status   = ST_TRUNC;
               end else begin
                  if (rem_dec == 16'd0) begin
                     phase_in = PH_TAG;
                  end
                  if (match_ff) begin
                     res_in.valid        = 1'b1;
                     res_in.rec_tag      = cur_tag_ff;
                     res_in.rec_kind     = cur_kind_ff;
                     res_in.rec_value    = {24'd0, req_in_byte};
                     res_in.payload_last = (rem_dec == 16'd0);
                     res_in.status       = ST_PAYLOAD;
                  end else if (req_in_last) begin
                     res_in.valid  = 1'b1;
                     res_in.status = ST_CLEAN;
                  end
               end
            end
            default: begin
               // expecting a tag byte
               phase_in = PH_TAG;
               if (req_in_byte == 8'd0) begin
                  cur_tag_in    = 8'd0;
                  cur_kind_in   = KIND_U8;
                  halted_in     = !req_in_last;
                  res_in.valid  = 1'b1;
                  res_in.status = ST_TERM;
               end else begin
                  cur_tag_in   = req_in_byte;
                  cur_kind_in  = KIND_U8;
                  accum_in     = 32'd0;
                  remaining_in = 16'd0;
                  match_in     = (target_tag_ff == 8'd0) || (target_tag_ff == req_in_byte);
                  if (req_in_last) begin
                     res_in.valid   = 1'b1;
                     res_in.rec_tag = req_in_byte;
                     res_in.status  = ST_TRUNC;
                  end else begin
                     phase_in = PH_TYPE;
                  end
               end
            end
         endcase
      end
   end

   assign rsp_load = accept && res_in.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_TAG;
         cur_tag_ff   <= 8'd0;
         cur_kind_ff  <= KIND_U8;
         remaining_ff <= 16'd0;
         accum_ff     <= 32'd0;
         match_ff     <= 1'b0;
         halted_ff    <= 1'b0;
         rsp_ff.valid <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff     <= phase_in;
            cur_tag_ff   <= cur_tag_in;
            cur_kind_ff  <= cur_kind_in;
            remaining_ff <= remaining_in;
            accum_ff     <= accum_in;
            match_ff     <= match_in;
            halted_ff    <= halted_in;
         end
         if (rsp_load) begin
            rsp_ff <= res_in;
         end else if (rsp_ready) begin
            rsp_ff.valid <= 1'b0;
         end
      end
   end

   assign rsp_valid        = rsp_ff.valid;
   assign rsp_rec_tag      = rsp_ff.rec_tag;
   assign rsp_rec_kind     = rsp_ff.rec_kind;
   assign rsp_rec_value    = rsp_ff.rec_value;
   assign rsp_payload_last = rsp_ff.payload_last;
   assign rsp_status       = rsp_ff.status;
   assign rsp_buffer_done  = rsp_ff.buffer_done;

   // a halted parser always resumes at a tag
   assert property (@(posedge clock) disable iff (reset) halted_ff |-> phase_ff == PH_TAG)
      else $error("halted parser not in tag phase");

   // payload phase always has bytes left to take
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> remaining_ff != 16'd0)
      else $error("payload phase with no bytes remaining");

   // payload bytes only come from string or byte-array records
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_PAYLOAD |->
         rsp_rec_kind == KIND_STRING || rsp_rec_kind == KIND_BYTES)
      else $error("payload item from numeric record");

   // payload_last only on payload items
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload_last |-> rsp_status == ST_PAYLOAD)
      else $error("payload_last on non-payload item");

   // truncation and clean end only answer the last byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_TRUNC || rsp_status == ST_CLEAN) |-> rsp_buffer_done)
      else $error("end status without buffer_done");

endmodule
